// ----- hdl/sas_pkg.sv -----
package sas_pkg;

	localparam int MAX_ROWS_DEF  = 16;
	localparam int TIME_BITS_DEF = 16;

	localparam int ROW_W    = 4;
	localparam int FRAME_W  = 8;
	localparam int PERIOD_W = 16;
	localparam int SIZE_W   = 12;
	localparam int ROWS_W   = 5;
	localparam int CLIPX_W  = 20;
	localparam int CLIPY_W  = 16;

	typedef enum logic [2:0] {
		REQ_TICK   = 3'd0,
		REQ_SELECT = 3'd1,
		REQ_WRITE  = 3'd2,
		REQ_FRAME  = 3'd3,
		REQ_RESET  = 3'd4
	} req_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [FRAME_W-1:0]  count;
		logic [PERIOD_W-1:0] delay;
		logic                loop;
		logic [SIZE_W-1:0]   w;
		logic [SIZE_W-1:0]   h;
	} cfg_t;

endpackage

// ----- hdl/sprite_animation_sequencer.sv -----
// An item steps through S_EXEC, then S_FILL once per row that a settings write fills,
// then S_SUM once per row from 0 to the active row, then S_LAST; done is registered from S_LAST.
// Throughput: one item at a time; busy stays high until the strobe. The row walk that
// sums clip heights through the settings memory sets how long an item takes.
// The receiver cannot stall: done is a single-cycle strobe.
// Reset (arst_n low, asynchronous): no rows in use, row 0 selected, all status cleared.
module sprite_animation_sequencer #(
	parameter int MAX_ROWS  = sas_pkg::MAX_ROWS_DEF,
	parameter int TIME_BITS = sas_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    req_type,
	input  logic [sas_pkg::PERIOD_W-1:0]  time_delta,
	input  logic [sas_pkg::ROW_W-1:0]     row_index,
	input  logic [sas_pkg::FRAME_W-1:0]   frame_value,
	input  logic [sas_pkg::PERIOD_W-1:0]  frame_period,
	input  logic [sas_pkg::FRAME_W-1:0]   frame_count,
	input  logic [sas_pkg::PERIOD_W-1:0]  delay_period,
	input  logic                          loop_enable,
	input  logic [sas_pkg::SIZE_W-1:0]    clip_width_in,
	input  logic [sas_pkg::SIZE_W-1:0]    clip_height_in,
	output logic                          done,
	output logic [sas_pkg::ROW_W-1:0]     active_row,
	output logic [sas_pkg::FRAME_W-1:0]   active_frame,
	output logic                          finished,
	output logic                          in_delay,
	output logic [sas_pkg::CLIPX_W-1:0]   clip_x,
	output logic [sas_pkg::CLIPY_W-1:0]   clip_y,
	output logic [sas_pkg::SIZE_W-1:0]    clip_w,
	output logic [sas_pkg::SIZE_W-1:0]    clip_h,
	output logic [sas_pkg::ROWS_W-1:0]    rows_used
);

	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int SW = TIME_BITS + 10;

	typedef struct packed {
		logic                         done;
		logic                         dly;
		logic [TIME_BITS-1:0]         acc;
		logic [sas_pkg::FRAME_W-1:0]  frame;
	} stat_t;

	typedef enum logic [2:0] {S_IDLE, S_EXEC, S_FILL, S_SUM, S_LAST} state_t;

	state_t                          state_q;
	sas_pkg::req_t                   req_q;
	logic [sas_pkg::PERIOD_W-1:0]    delta_q;
	logic [sas_pkg::ROW_W-1:0]       idx_q;
	logic [sas_pkg::FRAME_W-1:0]     fval_q;
	sas_pkg::cfg_t                   wcfg_q;
	logic [sas_pkg::ROW_W-1:0]       cur_q;
	logic [sas_pkg::ROWS_W-1:0]      rows_q;
	logic [sas_pkg::ROW_W-1:0]       fill_q;
	logic [sas_pkg::ROW_W-1:0]       k_q;
	logic                            add_s1;
	logic [sas_pkg::CLIPY_W-1:0]     ysum_q;
	logic                            done_q;
	logic [sas_pkg::FRAME_W-1:0]     frame_q;
	logic                            fin_q;
	logic                            dly_q;
	logic [sas_pkg::CLIPX_W-1:0]     clip_x_q;
	logic [sas_pkg::CLIPY_W-1:0]     clip_y_q;
	logic [sas_pkg::SIZE_W-1:0]      clip_w_q;
	logic [sas_pkg::SIZE_W-1:0]      clip_h_q;

	sas_pkg::cfg_t                   cfg_rd;
	logic [SW-1:0]                   stat_rd;
	logic [SW-1:0]                   stat_tick;
	logic [SW-1:0]                   stat_wdata;
	stat_t                           stat_frm;
	stat_t                           stat_cur;
	logic                            cfg_we;
	logic                            stat_we;
	logic                            stat_clear;
	logic [AW-1:0]                   cfg_raddr;
	logic [AW-1:0]                   stat_waddr;
	logic                            gap_row;
	logic                            rows_nz;

	assign rows_nz   = (rows_q != '0);
	assign gap_row   = ({1'b0, fill_q} >= rows_q);
	assign cfg_raddr = AW'((state_q == S_SUM) ? k_q : cur_q);
	assign cfg_we    = (state_q == S_FILL);
	assign stat_clear = (state_q == S_EXEC) && (req_q == sas_pkg::REQ_RESET);

	always_comb begin
		stat_frm       = stat_t'(stat_rd);
		stat_frm.frame = fval_q;
		stat_we        = 1'b0;
		stat_waddr     = AW'(cur_q);
		stat_wdata     = stat_tick;
		if (state_q == S_EXEC && rows_nz) begin
			if (req_q == sas_pkg::REQ_TICK) begin
				stat_we = 1'b1;
			end else if (req_q == sas_pkg::REQ_FRAME) begin
				stat_we    = 1'b1;
				stat_wdata = SW'(stat_frm);
			end
		end else if (state_q == S_FILL && gap_row) begin
			// rows added past the end start with a zero status
			stat_we    = 1'b1;
			stat_waddr = AW'(fill_q);
			stat_wdata = '0;
		end
	end

	sas_cfg_mem #(.MAX_ROWS(MAX_ROWS), .AW(AW)) u_cfg_mem (
		.clk   (clk),
		.we    (cfg_we),
		.waddr (AW'(fill_q)),
		.wdata (wcfg_q),
		.raddr (cfg_raddr),
		.rdata (cfg_rd)
	);

	sas_stat_mem #(.MAX_ROWS(MAX_ROWS), .SW(SW), .AW(AW)) u_stat_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (stat_clear),
		.we     (stat_we),
		.waddr  (stat_waddr),
		.wdata  (stat_wdata),
		.raddr  (AW'(cur_q)),
		.rdata  (stat_rd)
	);

	sas_tick #(.TIME_BITS(TIME_BITS), .SW(SW)) u_tick (
		.cfg      (cfg_rd),
		.stat_in  (stat_rd),
		.delta    (delta_q),
		.stat_out (stat_tick)
	);

	assign stat_cur = stat_t'(stat_rd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			req_q    <= sas_pkg::REQ_TICK;
			delta_q  <= '0;
			idx_q    <= '0;
			fval_q   <= '0;
			wcfg_q   <= '0;
			cur_q    <= '0;
			rows_q   <= '0;
			fill_q   <= '0;
			k_q      <= '0;
			add_s1   <= 1'b0;
			ysum_q   <= '0;
			done_q   <= 1'b0;
			frame_q  <= '0;
			fin_q    <= 1'b0;
			dly_q    <= 1'b0;
			clip_x_q <= '0;
			clip_y_q <= '0;
			clip_w_q <= '0;
			clip_h_q <= '0;
		end else begin
			done_q <= (state_q == S_LAST);
			add_s1 <= (state_q == S_SUM) && (k_q != cur_q);
			if (add_s1) begin
				ysum_q <= ysum_q + sas_pkg::CLIPY_W'(cfg_rd.h);
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q         <= sas_pkg::req_t'(req_type);
						delta_q       <= time_delta;
						idx_q         <= row_index;
						fval_q        <= frame_value;
						wcfg_q.period <= frame_period;
						wcfg_q.count  <= frame_count;
						wcfg_q.delay  <= delay_period;
						wcfg_q.loop   <= loop_enable;
						wcfg_q.w      <= clip_width_in;
						wcfg_q.h      <= clip_height_in;
						ysum_q        <= '0;
						state_q       <= S_EXEC;
					end
				end
				S_EXEC: begin
					k_q <= '0;
					unique case (req_q)
						sas_pkg::REQ_SELECT: begin
							cur_q   <= ({1'b0, idx_q} < rows_q) ? idx_q : '0;
							state_q <= S_SUM;
						end
						sas_pkg::REQ_WRITE: begin
							if (32'(idx_q) < MAX_ROWS) begin
								fill_q  <= ({1'b0, idx_q} >= rows_q) ?
									rows_q[sas_pkg::ROW_W-1:0] : idx_q;
								state_q <= S_FILL;
							end else begin
								state_q <= S_SUM;
							end
						end
						default: begin
							state_q <= S_SUM;
						end
					endcase
				end
				S_FILL: begin
					if (fill_q == idx_q) begin
						if ({1'b0, idx_q} >= rows_q) begin
							rows_q <= {1'b0, idx_q} + 1'b1;
						end
						state_q <= S_SUM;
					end else begin
						fill_q <= fill_q + 1'b1;
					end
				end
				S_SUM: begin
					// walk rows 0 to current; heights of earlier rows accumulate
					if (k_q == cur_q) begin
						state_q <= S_LAST;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_LAST: begin
					if (rows_nz) begin
						frame_q  <= stat_cur.frame;
						fin_q    <= stat_cur.done;
						dly_q    <= stat_cur.dly;
						clip_x_q <= sas_pkg::CLIPX_W'(cfg_rd.w) *
							sas_pkg::CLIPX_W'(stat_cur.frame);
						clip_y_q <= ysum_q;
						clip_w_q <= cfg_rd.w;
						clip_h_q <= cfg_rd.h;
					end else begin
						frame_q  <= '0;
						fin_q    <= 1'b0;
						dly_q    <= 1'b0;
						clip_x_q <= '0;
						clip_y_q <= '0;
						clip_w_q <= '0;
						clip_h_q <= '0;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign active_row   = cur_q;
	assign active_frame = frame_q;
	assign finished     = fin_q;
	assign in_delay     = dly_q;
	assign clip_x       = clip_x_q;
	assign clip_y       = clip_y_q;
	assign clip_w       = clip_w_q;
	assign clip_h       = clip_h_q;
	assign rows_used    = rows_q;

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_LAST))
		else $error("result strobe without a completed row walk");

	a_rows_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rows_q) <= MAX_ROWS)
		else $error("rows in use exceed table depth");

	a_cur_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cur_q} < rows_q) || (cur_q == '0))
		else $error("current row not in use");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_fill_no_stat_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> !stat_clear && cfg_we)
		else $error("fill step without settings write");

endmodule

// ----- hdl/sas_cfg_mem.sv -----
module sas_cfg_mem #(
	parameter int MAX_ROWS = sas_pkg::MAX_ROWS_DEF,
	parameter int AW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  sas_pkg::cfg_t   wdata,
	input  logic [AW-1:0]   raddr,
	output sas_pkg::cfg_t   rdata
);

	sas_pkg::cfg_t mem [MAX_ROWS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/sas_stat_mem.sv -----
module sas_stat_mem #(
	parameter int MAX_ROWS = sas_pkg::MAX_ROWS_DEF,
	parameter int SW       = sas_pkg::TIME_BITS_DEF + 10,
	parameter int AW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [SW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [SW-1:0] rdata
);

	logic [SW-1:0]       mem [MAX_ROWS];
	logic [MAX_ROWS-1:0] valid_q;
	logic [SW-1:0]       rd_q;
	logic                rd_valid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[raddr];
			if (clear) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	// an entry never written since the last clear reads as zero status
	assign rdata = rd_valid_q ? rd_q : '0;

endmodule

// ----- hdl/sas_tick.sv -----
module sas_tick #(
	parameter int TIME_BITS = sas_pkg::TIME_BITS_DEF,
	parameter int SW        = TIME_BITS + 10
) (
	input  sas_pkg::cfg_t                   cfg,
	input  logic [SW-1:0]                   stat_in,
	input  logic [sas_pkg::PERIOD_W-1:0]    delta,
	output logic [SW-1:0]                   stat_out
);

	localparam int SUMW = ((TIME_BITS > sas_pkg::PERIOD_W) ? TIME_BITS : sas_pkg::PERIOD_W) + 1;

	typedef struct packed {
		logic                         done;
		logic                         dly;
		logic [TIME_BITS-1:0]         acc;
		logic [sas_pkg::FRAME_W-1:0]  frame;
	} stat_t;

	stat_t             s_in;
	stat_t             s_out;
	logic [SUMW-1:0]   sum;
	logic [SUMW-1:0]   tmax;
	logic [SUMW-1:0]   acc_sat;
	logic [SUMW-1:0]   dly_w;
	logic [SUMW-1:0]   per_w;
	logic [sas_pkg::FRAME_W:0] nf;

	assign s_in  = stat_t'(stat_in);
	assign tmax  = SUMW'({TIME_BITS{1'b1}});
	assign sum   = SUMW'(s_in.acc) + SUMW'(delta);
	assign dly_w = SUMW'(cfg.delay);
	assign per_w = SUMW'(cfg.period);

	always_comb begin
		acc_sat = (sum > tmax) ? tmax : sum;
		nf      = {1'b0, s_in.frame} + 1'b1;
		s_out   = s_in;
		s_out.acc = TIME_BITS'(acc_sat);
		if (s_in.dly) begin
			if (acc_sat >= dly_w) begin
				s_out.frame = '0;
				s_out.acc   = TIME_BITS'(acc_sat - dly_w);
				s_out.dly   = 1'b0;
			end
		end else if (acc_sat >= per_w) begin
			s_out.acc   = TIME_BITS'(acc_sat - per_w);
			s_out.frame = nf[sas_pkg::FRAME_W-1:0];
			// end of row: restart, finish or wait out the delay
			if (nf >= {1'b0, cfg.count}) begin
				if (cfg.delay == '0) begin
					if (cfg.loop) begin
						s_out.frame = '0;
					end else begin
						s_out.done  = 1'b1;
						s_out.frame = s_in.frame;
					end
				end else begin
					s_out.dly   = 1'b1;
					s_out.frame = s_in.frame;
				end
			end
		end
	end

	assign stat_out = SW'(s_out);

endmodule

// ----- dv/tb_sprite_animation_sequencer.sv -----
module tb_sprite_animation_sequencer;
	import sas_pkg::*;

	localparam int          ROWS         = MAX_ROWS_DEF;
	localparam logic [2:0]  REQ_SPARE_LO = 3'd5;
	localparam logic [2:0]  REQ_SPARE_HI = 3'd7;
	localparam int          RANDOM_ITEMS = 1880;
	localparam int          STALL_LIMIT  = 1000;
	localparam int          DRAIN_CYCLES = 40;
	localparam int          N_DIRECTED   = 21;

	typedef struct packed {
		logic [2:0]          kind;
		logic [PERIOD_W-1:0] delta;
		logic [ROW_W-1:0]    row;
		logic [FRAME_W-1:0]  frame_value;
		logic [PERIOD_W-1:0] period;
		logic [FRAME_W-1:0]  count;
		logic [PERIOD_W-1:0] delay;
		logic                loop;
		logic [SIZE_W-1:0]   w;
		logic [SIZE_W-1:0]   h;
	} anim_req_t;

	typedef struct packed {
		logic [ROW_W-1:0]   active_row;
		logic [FRAME_W-1:0] active_frame;
		logic               finished;
		logic               in_delay;
		logic [CLIPX_W-1:0] clip_x;
		logic [CLIPY_W-1:0] clip_y;
		logic [SIZE_W-1:0]  clip_w;
		logic [SIZE_W-1:0]  clip_h;
		logic [ROWS_W-1:0]  rows_used;
	} sprite_view_t;

	typedef struct packed {
		logic [FRAME_W-1:0]  frame;
		logic [PERIOD_W-1:0] acc;
		logic                delaying;
		logic                ended;
	} row_stat_t;

	typedef struct packed {
		anim_req_t    req;
		logic         typed;
		sprite_view_t view;
	} plan_row_t;

	localparam sprite_view_t EMPTY_VIEW = '0;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [2:0]          req_type;
	logic [PERIOD_W-1:0] time_delta;
	logic [ROW_W-1:0]    row_index;
	logic [FRAME_W-1:0]  frame_value;
	logic [PERIOD_W-1:0] frame_period;
	logic [FRAME_W-1:0]  frame_count;
	logic [PERIOD_W-1:0] delay_period;
	logic                loop_enable;
	logic [SIZE_W-1:0]   clip_width_in;
	logic [SIZE_W-1:0]   clip_height_in;
	logic                done;
	logic [ROW_W-1:0]    active_row;
	logic [FRAME_W-1:0]  active_frame;
	logic                finished;
	logic                in_delay;
	logic [CLIPX_W-1:0]  clip_x;
	logic [CLIPY_W-1:0]  clip_y;
	logic [SIZE_W-1:0]   clip_w;
	logic [SIZE_W-1:0]   clip_h;
	logic [ROWS_W-1:0]   rows_used;

	cfg_t         anim_cfg [ROWS];
	row_stat_t    anim_stat [ROWS];
	logic [4:0]   rows_live;
	logic [3:0]   sel_row;
	sprite_view_t expected_views [$];
	int           mismatch_count = 0;
	int           views_checked = 0;
	int           items_sent;
	int           idle_cycles = 0;
	int           kind_seen [8];

	// Rows: extremes and every special case, with the obvious outcomes typed in.
	plan_row_t plan [N_DIRECTED] = '{
		'{'{REQ_TICK, 16'hFFFF, 4'd0, 8'd0, 16'd0, 8'd0, 16'd0, 1'b0, 12'd0, 12'd0},
			1'b1, EMPTY_VIEW},
		'{'{REQ_FRAME, 16'd0, 4'd0, 8'd255, 16'd0, 8'd0, 16'd0, 1'b0, 12'd0, 12'd0},
			1'b1, EMPTY_VIEW},
		'{'{REQ_SELECT, 16'd0, 4'd15, 8'd0, 16'd0, 8'd0, 16'd0, 1'b0, 12'd0, 12'd0},
			1'b1, EMPTY_VIEW},
		'{'{REQ_SPARE_HI, 16'hFFFF, 4'd15, 8'd255, 16'hFFFF, 8'd255, 16'hFFFF, 1'b1,
			12'hFFF, 12'hFFF}, 1'b1, EMPTY_VIEW},
		'{'{REQ_WRITE, 16'd0, 4'd0, 8'd0, 16'd100, 8'd3, 16'd0, 1'b1, 12'hFFF, 12'hFFF},
			1'b1, '{4'd0, 8'd0, 1'b0, 1'b0, 20'd0, 16'd0, 12'd4095, 12'd4095, 5'd1}},
		'{'{REQ_TICK, 16'd100, 4'd0, 8'd0, 16'd0, 8'd0, 16'd0, 1'b0, 12'd0, 12'd0},
			1'b0, EMPTY_VIEW},
		'{'{REQ_TICK, 16'hFFFF, 4'd0, 8'd0, 16'd0, 8'd0, 16'd0, 1'b0, 12'd0, 12'd0},
			1'b0, EMPTY_VIEW},
		'{'{REQ_TICK, 16'd0, 4'd0, 8'd0, 16'd0, 8'd0, 16'd0, 1'b0, 12'd0, 12'd0},
			1'b0, EMPTY_VIEW},
		'{'{REQ_FRAME, 16'd0, 4'd0, 8'd255, 16'd0, 8'd0, 16'd0, 1'b0, 12'd0, 12'd0},
			1'b1, '{4'd0, 8'd255, 1'b0, 1'b0, 20'd1044225, 16'd0, 12'd4095, 12'd4095,
			5'd1}},
		'{'{REQ_TICK, 16'd100, 4'd0, 8'd0, 16'd0, 8'd0, 16'd0, 1'b0, 12'd0, 12'd0},
			1'b0, EMPTY_VIEW},
		'{'{REQ_WRITE, 16'd0, 4'd15, 8'd0, 16'd0, 8'd0, 16'd0, 1'b0, 12'd1, 12'hFFF},
			1'b0, EMPTY_VIEW},
		'{'{REQ_SELECT, 16'd0, 4'd15, 8'd0, 16'd0, 8'd0, 16'd0, 1'b0, 12'd0, 12'd0},
			1'b1, '{4'd15, 8'd0, 1'b0, 1'b0, 20'd0, 16'd61425, 12'd1, 12'd4095, 5'd16}},
		'{'{REQ_TICK, 16'd0, 4'd0, 8'd0, 16'd0, 8'd0, 16'd0, 1'b0, 12'd0, 12'd0},
			1'b0, EMPTY_VIEW},
		'{'{REQ_TICK, 16'd5, 4'd0, 8'd0, 16'd0, 8'd0, 16'd0, 1'b0, 12'd0, 12'd0},
			1'b0, EMPTY_VIEW},
		'{'{REQ_WRITE, 16'd0, 4'd15, 8'd0, 16'd10, 8'd2, 16'hFFFF, 1'b1, 12'd7, 12'd3},
			1'b0, EMPTY_VIEW},
		'{'{REQ_RESET, 16'd0, 4'd0, 8'd0, 16'd0, 8'd0, 16'd0, 1'b0, 12'd0, 12'd0},
			1'b1, '{4'd15, 8'd0, 1'b0, 1'b0, 20'd0, 16'd61425, 12'd7, 12'd3, 5'd16}},
		'{'{REQ_TICK, 16'd10, 4'd0, 8'd0, 16'd0, 8'd0, 16'd0, 1'b0, 12'd0, 12'd0},
			1'b0, EMPTY_VIEW},
		'{'{REQ_TICK, 16'd10, 4'd0, 8'd0, 16'd0, 8'd0, 16'd0, 1'b0, 12'd0, 12'd0},
			1'b0, EMPTY_VIEW},
		'{'{REQ_TICK, 16'hFFFF, 4'd0, 8'd0, 16'd0, 8'd0, 16'd0, 1'b0, 12'd0, 12'd0},
			1'b0, EMPTY_VIEW},
		'{'{REQ_SELECT, 16'd0, 4'd0, 8'd0, 16'd0, 8'd0, 16'd0, 1'b0, 12'd0, 12'd0},
			1'b0, EMPTY_VIEW},
		'{'{REQ_SPARE_LO, 16'd0, 4'd3, 8'd0, 16'd0, 8'd0, 16'd0, 1'b0, 12'd0, 12'd0},
			1'b0, EMPTY_VIEW}
	};

	sprite_animation_sequencer DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.time_delta     (time_delta),
		.row_index      (row_index),
		.frame_value    (frame_value),
		.frame_period   (frame_period),
		.frame_count    (frame_count),
		.delay_period   (delay_period),
		.loop_enable    (loop_enable),
		.clip_width_in  (clip_width_in),
		.clip_height_in (clip_height_in),
		.done           (done),
		.active_row     (active_row),
		.active_frame   (active_frame),
		.finished       (finished),
		.in_delay       (in_delay),
		.clip_x         (clip_x),
		.clip_y         (clip_y),
		.clip_w         (clip_w),
		.clip_h         (clip_h),
		.rows_used      (rows_used)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Apply one item to the animation table and return the view it leaves.
	function automatic sprite_view_t step_animation(anim_req_t r);
		sprite_view_t v;
		cfg_t         c;
		logic [16:0]  sum;
		logic [8:0]   nf;
		logic [15:0]  ysum;
		int           i;
		v = '0;
		case (r.kind)
			REQ_TICK: if (rows_live != 0) begin
				c   = anim_cfg[sel_row];
				sum = {1'b0, anim_stat[sel_row].acc} + {1'b0, r.delta};
				anim_stat[sel_row].acc = sum[16] ? 16'hFFFF : sum[15:0];
				if (anim_stat[sel_row].delaying) begin
					if (anim_stat[sel_row].acc >= c.delay) begin
						anim_stat[sel_row].frame    = '0;
						anim_stat[sel_row].acc      = anim_stat[sel_row].acc - c.delay;
						anim_stat[sel_row].delaying = 1'b0;
					end
				end else if (anim_stat[sel_row].acc >= c.period) begin
					nf = {1'b0, anim_stat[sel_row].frame} + 9'd1;
					anim_stat[sel_row].acc = anim_stat[sel_row].acc - c.period;
					if (nf >= {1'b0, c.count}) begin
						if (c.delay == 0 && c.loop) begin
							nf = '0;
						end else begin
							// finish on the last frame, or hold it through the delay
							if (c.delay == 0)
								anim_stat[sel_row].ended = 1'b1;
							else
								anim_stat[sel_row].delaying = 1'b1;
							nf = nf - 9'd1;
						end
					end
					anim_stat[sel_row].frame = nf[7:0];
				end
			end
			REQ_SELECT: sel_row = ({1'b0, r.row} < rows_live) ? r.row : '0;
			REQ_WRITE: begin
				c = '{r.period, r.count, r.delay, r.loop, r.w, r.h};
				if ({1'b0, r.row} >= rows_live) begin
					// fill the gap up to the written row with copies
					for (i = int'(rows_live); i <= int'(r.row); i++) begin
						anim_cfg[i]  = c;
						anim_stat[i] = '0;
					end
					rows_live = {1'b0, r.row} + 5'd1;
				end else begin
					anim_cfg[r.row] = c;
				end
			end
			REQ_FRAME: if (rows_live != 0) anim_stat[sel_row].frame = r.frame_value;
			REQ_RESET: for (i = 0; i < ROWS; i++) anim_stat[i] = '0;
			default: ;
		endcase
		v.active_row = sel_row;
		v.rows_used  = rows_live;
		if (rows_live != 0) begin
			ysum = '0;
			for (i = 0; i < int'(sel_row); i++)
				ysum = ysum + CLIPY_W'(anim_cfg[i].h);
			v.active_frame = anim_stat[sel_row].frame;
			v.finished     = anim_stat[sel_row].ended;
			v.in_delay     = anim_stat[sel_row].delaying;
			v.clip_x       = CLIPX_W'(anim_cfg[sel_row].w) * CLIPX_W'(anim_stat[sel_row].frame);
			v.clip_y       = ysum;
			v.clip_w       = anim_cfg[sel_row].w;
			v.clip_h       = anim_cfg[sel_row].h;
		end
		return v;
	endfunction

	function automatic anim_req_t random_request();
		anim_req_t r;
		int        pick;
		r = {$urandom, $urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			r.kind  = REQ_TICK;
			r.delta = ($urandom_range(0, 4) != 0) ? PERIOD_W'($urandom_range(0, 300)) : r.delta;
		end else if (pick < 62) begin
			r.kind = REQ_SELECT;
		end else if (pick < 74) begin
			r.kind   = REQ_WRITE;
			r.period = ($urandom_range(0, 4) != 0) ? PERIOD_W'($urandom_range(0, 150)) : r.period;
			r.count  = ($urandom_range(0, 6) != 0) ? FRAME_W'($urandom_range(0, 6)) : r.count;
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9: r.delay = '0;
				10, 11, 12, 13, 14, 15, 16: r.delay = PERIOD_W'($urandom_range(1, 300));
				default: ;
			endcase
		end else if (pick < 84) begin
			r.kind = REQ_FRAME;
			if ($urandom_range(0, 9) < 7)
				r.frame_value = FRAME_W'($urandom_range(0, 7));
		end else if (pick < 88) begin
			r.kind = REQ_RESET;
		end else if (pick < 92) begin
			r.kind = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
		end else begin
			r.kind = REQ_TICK;
		end
		return r;
	endfunction

	// Offer one item, hold start until it is taken, then idle for the drawn gap.
	task automatic send_request(anim_req_t r, logic typed, sprite_view_t typed_view, int gap);
		sprite_view_t predicted;
		start          <= 1'b1;
		req_type       <= r.kind;
		time_delta     <= r.delta;
		row_index      <= r.row;
		frame_value    <= r.frame_value;
		frame_period   <= r.period;
		frame_count    <= r.count;
		delay_period   <= r.delay;
		loop_enable    <= r.loop;
		clip_width_in  <= r.w;
		clip_height_in <= r.h;
		@(posedge clk);
		while (busy) @(posedge clk);
		predicted = step_animation(r);
		expected_views.insert(expected_views.size(), typed ? typed_view : predicted);
		items_sent++;
		kind_seen[r.kind]++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic void check_field(string name, int expv, int actv);
		if (expv != actv) begin
			$error("%s: expected %0d, got %0d", name, expv, actv);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		sprite_view_t e;
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$error("no handshake for %0d cycles", STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
			if (done) begin
				if (expected_views.size() == 0) begin
					$error("result strobe with no item outstanding");
					mismatch_count++;
				end else begin
					e = expected_views.pop_front();
					views_checked++;
					check_field("active_row", e.active_row, active_row);
					check_field("active_frame", e.active_frame, active_frame);
					check_field("finished", e.finished, finished);
					check_field("in_delay", e.in_delay, in_delay);
					check_field("clip_x", e.clip_x, clip_x);
					check_field("clip_y", e.clip_y, clip_y);
					check_field("clip_w", e.clip_w, clip_w);
					check_field("clip_h", e.clip_h, clip_h);
					check_field("rows_used", e.rows_used, rows_used);
				end
			end
		end
	end

	initial begin
		logic gappy;
		int   k;
		arst_n         = 1'b0;
		start          = 1'b0;
		req_type       = '0;
		time_delta     = '0;
		row_index      = '0;
		frame_value    = '0;
		frame_period   = '0;
		frame_count    = '0;
		delay_period   = '0;
		loop_enable    = 1'b0;
		clip_width_in  = '0;
		clip_height_in = '0;
		items_sent     = 0;
		rows_live      = '0;
		sel_row        = '0;
		gappy          = 1'b1;
		for (k = 0; k < 8; k++) kind_seen[k] = 0;
		for (k = 0; k < ROWS; k++) begin
			anim_cfg[k]  = '0;
			anim_stat[k] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < N_DIRECTED; k++)
			send_request(plan[k].req, plan[k].typed, plan[k].view, $urandom_range(0, 16));

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			// alternate stretches with and without sender gaps
			if (k % 150 == 0)
				gappy = (k == 0) ? 1'b0 : 1'(($urandom_range(0, 2) != 0));
			if (k == RANDOM_ITEMS / 2) begin
				start <= 1'b0;
				@(posedge clk);
				while (expected_views.size() != 0) @(posedge clk);
			end
			send_request(random_request(), 1'b0, EMPTY_VIEW, gappy ? $urandom_range(0, 16) : 0);
		end
		start <= 1'b0;

		while (expected_views.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d items sent, %0d results checked, %0d mismatches",
			items_sent, views_checked, mismatch_count);
		$display("ticks %0d, selects %0d, writes %0d, frame sets %0d, resets %0d, spare %0d",
			kind_seen[REQ_TICK], kind_seen[REQ_SELECT], kind_seen[REQ_WRITE],
			kind_seen[REQ_FRAME], kind_seen[REQ_RESET],
			kind_seen[5] + kind_seen[6] + kind_seen[7]);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
